### src/assert_macros.svh
// Assertion macros used by the queue RTL (mpq_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/mpq_pkg.sv
// Package: sizes, codes and shared types of the priority queue.
package mpq_pkg;

   localparam int DEPTH          = 16;
   localparam int PAYLOAD_WIDTH  = 32;
   localparam int PRIORITY_WIDTH = 16;
   localparam int KIND_WIDTH     = 2;
   localparam int COUNT_WIDTH    = $clog2(DEPTH + 1);
   localparam int INDEX_WIDTH    = $clog2(DEPTH);

   typedef logic [KIND_WIDTH-1:0]            kind_type;
   typedef logic [PAYLOAD_WIDTH-1:0]         payload_type;
   typedef logic signed [PRIORITY_WIDTH-1:0] prio_type;
   typedef logic [COUNT_WIDTH-1:0]           count_type;
   typedef logic [INDEX_WIDTH-1:0]           index_type;

   // request kinds as they arrive on the port
   localparam kind_type KIND_ADD     = 2'd0;
   localparam kind_type KIND_EXTRACT = 2'd1;
   localparam kind_type KIND_CLEAR   = 2'd2;

   // decoded operations handed to the back end
   typedef logic [1:0] op_type;
   localparam op_type OP_ADD     = 2'd0;
   localparam op_type OP_EXTRACT = 2'd1;
   localparam op_type OP_CLEAR   = 2'd2;
   localparam op_type OP_NOP     = 2'd3;

   typedef struct packed {
      op_type      op;
      payload_type payload;
      prio_type    prio;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

endpackage

### src/mpq_ifs.sv
// Request and response channel interfaces.
interface mpq_req_if;
   import mpq_pkg::*;
   logic        valid;
   logic        ready;
   kind_type    kind;
   payload_type job_payload;
   prio_type    job_priority;

   modport source (output valid, kind, job_payload, job_priority, input ready);
   modport sink   (input valid, kind, job_payload, job_priority, output ready);
endinterface

interface mpq_rsp_if;
   import mpq_pkg::*;
   logic        valid;
   logic        ready;
   payload_type taken_payload;
   logic        taken_valid;
   logic        add_accepted;
   count_type   entry_count;
   logic        is_empty;
   logic        is_full;

   modport source (output valid, taken_payload, taken_valid, add_accepted,
                   entry_count, is_empty, is_full, input ready);
   modport sink   (input valid, taken_payload, taken_valid, add_accepted,
                   entry_count, is_empty, is_full, output ready);
endinterface

### src/mpq_front.sv
// Front end: takes requests, decodes the kind, holds them in a two-slot queue.
module mpq_front (
   input  logic                  clock,
   input  logic                  reset,
   mpq_req_if.sink               req_bus,
   output mpq_pkg::cmd_chan_type cmd_chan,
   input  logic                  cmd_pop
);
   import mpq_pkg::*;

   localparam logic [1:0] FILL_FULL = 2'd2;

   cmd_type    slots_ff [2];
   cmd_type    slots_in [2];
   logic [1:0] fill_ff, fill_in;
   logic [1:0] fill_after_pop;
   logic       push;
   cmd_type    req_cmd;

   always_comb begin
      req_cmd.payload = req_bus.job_payload;
      req_cmd.prio    = req_bus.job_priority;
      case (req_bus.kind)
         KIND_ADD:     req_cmd.op = OP_ADD;
         KIND_EXTRACT: req_cmd.op = OP_EXTRACT;
         KIND_CLEAR:   req_cmd.op = OP_CLEAR;
         default:      req_cmd.op = OP_NOP;
      endcase
   end

   assign req_bus.ready  = (fill_ff != FILL_FULL);
   assign push           = req_bus.valid && req_bus.ready;
   assign fill_after_pop = fill_ff - {1'b0, cmd_pop};

   always_comb begin
      slots_in = slots_ff;
      if (cmd_pop) begin
         slots_in[0] = slots_ff[1];
      end
      if (push) begin
         slots_in[fill_after_pop[0]] = req_cmd;
      end
      fill_in = fill_after_pop + {1'b0, push};
   end

   assign cmd_chan.valid = (fill_ff != 2'd0);
   assign cmd_chan.cmd   = slots_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
      end
      slots_ff <= slots_in;
   end

endmodule

### src/mpq_back.sv
// Back end: entry store, serial max scan, close-up and response register.
`include "assert_macros.svh"

module mpq_back (
   input  logic                 clock,
   input  logic                 reset,
   input  mpq_pkg::cmd_chan_type cmd_chan,
   output logic                 cmd_pop,
   mpq_rsp_if.source            rsp_bus
);
   import mpq_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_TAKE = 2'd2;

   payload_type pay_ff [DEPTH];
   payload_type pay_in [DEPTH];
   prio_type    pri_ff [DEPTH];
   prio_type    pri_in [DEPTH];
   count_type   count_ff, count_in;
   logic [1:0]  state_ff, state_in;
   index_type   scan_ff, scan_in;
   index_type   best_idx_ff, best_idx_in;
   prio_type    best_pri_ff, best_pri_in;
   payload_type best_pay_ff, best_pay_in;

   logic        rsp_valid_ff, rsp_valid_in;
   payload_type taken_payload_ff, taken_payload_in;
   logic        taken_valid_ff, taken_valid_in;
   logic        add_accepted_ff, add_accepted_in;
   count_type   rsp_count_ff, rsp_count_in;

   logic        out_free;
   logic        produce;
   logic        res_valid;
   logic        res_accept;
   payload_type res_payload;
   prio_type    scan_pri;
   payload_type scan_pay;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign scan_pri = pri_ff[scan_ff];
   assign scan_pay = pay_ff[scan_ff];

   always_comb begin
      pay_in      = pay_ff;
      pri_in      = pri_ff;
      count_in    = count_ff;
      state_in    = state_ff;
      scan_in     = scan_ff;
      best_idx_in = best_idx_ff;
      best_pri_in = best_pri_ff;
      best_pay_in = best_pay_ff;
      cmd_pop     = 1'b0;
      produce     = 1'b0;
      res_valid   = 1'b0;
      res_accept  = 1'b0;
      res_payload = '0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_chan.valid) begin
               case (cmd_chan.cmd.op)
                  OP_ADD: begin
                     if (out_free) begin
                        cmd_pop = 1'b1;
                        produce = 1'b1;
                        if (count_ff < COUNT_WIDTH'(DEPTH)) begin
                           pay_in[count_ff[INDEX_WIDTH-1:0]] = cmd_chan.cmd.payload;
                           pri_in[count_ff[INDEX_WIDTH-1:0]] = cmd_chan.cmd.prio;
                           count_in   = count_ff + COUNT_WIDTH'(1);
                           res_accept = 1'b1;
                        end
                     end
                  end
                  OP_EXTRACT: begin
                     if (count_ff != '0) begin
                        // scan runs without the response slot
                        cmd_pop  = 1'b1;
                        scan_in  = '0;
                        state_in = ST_SCAN;
                     end else if (out_free) begin
                        cmd_pop = 1'b1;
                        produce = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     if (out_free) begin
                        cmd_pop  = 1'b1;
                        produce  = 1'b1;
                        count_in = '0;
                     end
                  end
                  default: begin
                     if (out_free) begin
                        cmd_pop = 1'b1;
                        produce = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // strict compare keeps the earliest entry on a tie
            if (scan_ff == '0 || scan_pri > best_pri_ff) begin
               best_idx_in = scan_ff;
               best_pri_in = scan_pri;
               best_pay_in = scan_pay;
            end
            if (COUNT_WIDTH'(scan_ff) == count_ff - COUNT_WIDTH'(1)) begin
               state_in = ST_TAKE;
            end else begin
               scan_in = scan_ff + INDEX_WIDTH'(1);
            end
         end
         ST_TAKE: begin
            if (out_free) begin
               produce     = 1'b1;
               res_valid   = 1'b1;
               res_payload = best_pay_ff;
               for (int i = 0; i < DEPTH - 1; i++) begin
                  if (INDEX_WIDTH'(i) >= best_idx_ff) begin
                     pay_in[INDEX_WIDTH'(i)] = pay_ff[INDEX_WIDTH'(i + 1)];
                     pri_in[INDEX_WIDTH'(i)] = pri_ff[INDEX_WIDTH'(i + 1)];
                  end
               end
               count_in = count_ff - COUNT_WIDTH'(1);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      taken_payload_in = taken_payload_ff;
      taken_valid_in   = taken_valid_ff;
      add_accepted_in  = add_accepted_ff;
      rsp_count_in     = rsp_count_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (produce) begin
         rsp_valid_in     = 1'b1;
         taken_payload_in = res_payload;
         taken_valid_in   = res_valid;
         add_accepted_in  = res_accept;
         rsp_count_in     = count_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.taken_payload = taken_payload_ff;
   assign rsp_bus.taken_valid   = taken_valid_ff;
   assign rsp_bus.add_accepted  = add_accepted_ff;
   assign rsp_bus.entry_count   = rsp_count_ff;
   assign rsp_bus.is_empty      = (rsp_count_ff == '0);
   assign rsp_bus.is_full       = (rsp_count_ff == COUNT_WIDTH'(DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pay_ff           <= pay_in;
      pri_ff           <= pri_in;
      scan_ff          <= scan_in;
      best_idx_ff      <= best_idx_in;
      best_pri_ff      <= best_pri_in;
      best_pay_ff      <= best_pay_in;
      taken_payload_ff <= taken_payload_in;
      taken_valid_ff   <= taken_valid_in;
      add_accepted_ff  <= add_accepted_in;
      rsp_count_ff     <= rsp_count_in;
   end

   `ASSERT_IMPL(scan_nonempty, clock, reset, state_ff != ST_IDLE,
                count_ff != '0, "scan with empty store")
   `ASSERT_IMPL(scan_in_range, clock, reset, state_ff == ST_SCAN,
                COUNT_WIDTH'(scan_ff) < count_ff, "scan index past fill")
   `ASSERT_NEXT(take_drops_one, clock, reset, state_ff == ST_TAKE && out_free,
                count_ff == $past(count_ff) - COUNT_WIDTH'(1), "extract did not drop one entry")

endmodule

### src/max_priority_queue_unit.sv
// Top level of the bounded max priority queue.
//
// Requests arrive on req_bus (valid/ready): kind 0 adds job_payload with a
// signed job_priority, kind 1 extracts the highest priority entry (earliest
// added wins a tie), kind 2 clears, kind 3 does nothing. Each request gives
// exactly one response on rsp_bus with the extracted payload, its valid flag,
// the add-accepted flag, the entry count after the request and empty/full.
// The front end decodes requests into a two-slot queue, so up to two
// requests are taken while the back end is busy or the response is stalled.
// Add, clear and no-op pass through a front-end slot and the response
// register, and one of them completes per cycle while rsp_bus.ready stays
// high and no extract is in the back end. An extract with entries held
// runs a serial scan that reads one stored entry per cycle, then closes
// the gap and answers. An extract on an empty queue completes like an add.
// Reset (synchronous) empties the queue and drops any queued request and
// pending response. When the receiver stalls, the response register holds
// its value, the back end waits, and req_bus.ready falls once both queue
// slots are full.
module max_priority_queue_unit (
   input logic       clock,
   input logic       reset,
   mpq_req_if.sink   req_bus,
   mpq_rsp_if.source rsp_bus
);
   import mpq_pkg::*;

   cmd_chan_type cmd_chan;
   logic         cmd_pop;

   // decode and buffer
   mpq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .cmd_chan (cmd_chan),
      .cmd_pop  (cmd_pop)
   );

   // entry store and execution
   mpq_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_chan (cmd_chan),
      .cmd_pop  (cmd_pop),
      .rsp_bus  (rsp_bus)
   );

endmodule
